// ===== src/ssr_pkg.sv =====
package ssr_pkg;

  localparam int unsigned ECHO_W  = 15;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned STEP_W  = 7;
  localparam int unsigned CM_W    = 10;
  localparam int unsigned DIST_W  = 14;
  localparam int unsigned DUTY_W  = 13;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [ANGLE_W-1:0] ANGLE_FULL  = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_LEFT  = 8'd110;
  localparam logic [ANGLE_W-1:0] ANGLE_RIGHT = 8'd70;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;

  localparam logic [DUTY_W-1:0] DUTY_BASE     = 13'd1638;
  // 6226 = 34*180 + 106: the whole part is a plain multiply, the rest goes
  // through an exact reciprocal (2^24/180 rounded up) for products below 19081.
  localparam logic [DUTY_W-1:0] DUTY_WHOLE    = 13'd34;
  localparam logic [14:0]       DUTY_FRAC     = 15'd106;
  localparam logic [31:0]       DUTY_RECIP    = 32'd93207;

  localparam logic [23:0]       ECHO_SCALE    = 24'd281;
  localparam logic [DIST_W-1:0] MIN_DIST      = 14'd32;
  localparam logic [DIST_W:0]   PATH_MARGIN   = 15'd160;
  localparam logic [DIST_W-1:0] DIST_RESET    = 14'd3200;

  localparam logic [7:0] ECHO_NEW_Q8 = 8'd179;
  localparam logic [7:0] ECHO_OLD_Q8 = 8'd77;
  localparam logic [7:0] SECT_NEW_Q8 = 8'd154;
  localparam logic [7:0] SECT_OLD_Q8 = 8'd102;

  localparam logic [1:0] STATUS_CLEAR     = 2'd0;
  localparam logic [1:0] STATUS_OBSTACLE  = 2'd1;
  localparam logic [1:0] STATUS_VERYCLOSE = 2'd2;

  localparam logic [1:0] PATH_CENTER = 2'd0;
  localparam logic [1:0] PATH_LEFT   = 2'd1;
  localparam logic [1:0] PATH_RIGHT  = 2'd2;

  localparam logic [2:0] REG_MIN_ANGLE  = 3'd0;
  localparam logic [2:0] REG_MAX_ANGLE  = 3'd1;
  localparam logic [2:0] REG_SWEEP_STEP = 3'd2;
  localparam logic [2:0] REG_MAX_RANGE  = 3'd3;
  localparam logic [2:0] REG_VERY_CLOSE = 3'd4;
  localparam logic [2:0] REG_WARNING    = 3'd5;

  typedef struct packed {
    logic [ANGLE_W-1:0] min_angle;
    logic [ANGLE_W-1:0] max_angle;
    logic [STEP_W-1:0]  sweep_step;
    logic [CM_W-1:0]    max_range_cm;
    logic [CM_W-1:0]    very_close_cm;
    logic [CM_W-1:0]    warning_cm;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic angle;
    logic smooth;
    logic sector;
    logic finish;
  } cmd_t;

  function automatic logic [DIST_W-1:0] ema(input logic [DIST_W-1:0] nw,
                                            input logic [DIST_W-1:0] old,
                                            input logic [7:0] wn,
                                            input logic [7:0] wo);
    logic [21:0] acc;
    acc = 22'(nw) * 22'(wn) + 22'(old) * 22'(wo);
    return acc[21:8];
  endfunction

endpackage

// ===== src/sweep_radar_scan_step.sv =====
// Sweep radar scan step: each input transaction is one scan step carrying the
// echo width in microseconds (0 for timeout). The block advances the sweep
// angle, bounces it at the configured limits, and returns one result with the
// servo duty, the current distance in 1/16 cm, the three smoothed sector
// distances, the obstacle status, the best path and the front-blocked flag.
// A step is accepted only while the sequencer is idle, so a new step is not
// taken until the last one's result has gone into the output register:
// a four-step sequencer walks one datapath through angle, echo smoothing,
// sector smoothing and classification. Results wait in an output register,
// and the sequencer holds its last step while that register is still full.
// Configuration registers sit at byte addresses 0, 4, ... 20 in the order
// min_angle, max_angle, sweep_step, max_range_cm, very_close_cm, warning_cm.
module sweep_radar_scan_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ssr_pkg::IN_DATA_W-1:0]  s_tdata,   // [14:0] echo_us
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] angle, [20:8] servo_duty, [34:21] distance, [48:35] left sector,
  // [62:49] center sector, [76:63] right sector, [78:77] status,
  // [80:79] path choice, [81] front_blocked
  output logic [ssr_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [4:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ssr_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_angle     <= 8'd0;
      cfg.max_angle     <= 8'd180;
      cfg.sweep_step    <= 7'd2;
      cfg.max_range_cm  <= 10'd400;
      cfg.very_close_cm <= 10'd15;
      cfg.warning_cm    <= 10'd30;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_ANGLE:  cfg.min_angle     <= pwdata[ANGLE_W-1:0];
        REG_MAX_ANGLE:  cfg.max_angle     <= pwdata[ANGLE_W-1:0];
        REG_SWEEP_STEP: cfg.sweep_step    <= pwdata[STEP_W-1:0];
        REG_MAX_RANGE:  cfg.max_range_cm  <= pwdata[CM_W-1:0];
        REG_VERY_CLOSE: cfg.very_close_cm <= pwdata[CM_W-1:0];
        REG_WARNING:    cfg.warning_cm    <= pwdata[CM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_ANGLE:  prdata = 32'(cfg.min_angle);
      REG_MAX_ANGLE:  prdata = 32'(cfg.max_angle);
      REG_SWEEP_STEP: prdata = 32'(cfg.sweep_step);
      REG_MAX_RANGE:  prdata = 32'(cfg.max_range_cm);
      REG_VERY_CLOSE: prdata = 32'(cfg.very_close_cm);
      REG_WARNING:    prdata = 32'(cfg.warning_cm);
      default:        prdata = '0;
    endcase
  end

  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  ssr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .echo_in  (s_tdata[ECHO_W-1:0]),
    .out_data (m_tdata)
  );

endmodule

// ===== src/ssr_ctrl.sv =====
module ssr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output ssr_pkg::cmd_t cmd
);
  import ssr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_SMOOTH,
    ST_SECTOR,
    ST_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && s_tvalid;
    cmd.angle  = (state == ST_ANGLE);
    cmd.smooth = (state == ST_SMOOTH);
    cmd.sector = (state == ST_SECTOR);
    cmd.finish = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // load a finished result, else drop the one just taken
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_ANGLE;
        end
        ST_ANGLE:  state <= ST_SMOOTH;
        ST_SMOOTH: state <= ST_SECTOR;
        ST_SECTOR: state <= ST_FINISH;
        ST_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/ssr_dp.sv =====
module ssr_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  ssr_pkg::cmd_t                  cmd,
  input  ssr_pkg::cfg_t                  cfg,
  input  logic [ssr_pkg::ECHO_W-1:0]     echo_in,
  output logic [ssr_pkg::OUT_DATA_W-1:0] out_data
);
  import ssr_pkg::*;

  typedef enum logic [1:0] {
    SEC_CENTER,
    SEC_LEFT,
    SEC_RIGHT
  } sector_t;

  logic [ECHO_W-1:0]  echo;
  logic [DIST_W-1:0]  raw;
  logic [ANGLE_W-1:0] sweep_angle;
  logic               sweep_up;
  logic [DIST_W-1:0]  smoothed_echo;
  logic [DIST_W-1:0]  last_distance;
  logic [DIST_W-1:0]  left_memory;
  logic [DIST_W-1:0]  center_memory;
  logic [DIST_W-1:0]  right_memory;
  sector_t            sector;
  logic [14:0]        frac_prod;
  logic [6:0]         frac_quot;

  logic signed [9:0]  a_step;
  logic signed [9:0]  a_bounce;
  logic [ANGLE_W-1:0] angle_next;
  logic               sweep_up_next;
  logic [23:0]        raw_prod;
  logic [DIST_W-1:0]  range16;
  logic [DIST_W-1:0]  vc16;
  logic [DIST_W-1:0]  warn16;
  logic [DIST_W-1:0]  echo_target;
  logic [DIST_W-1:0]  smoothed_echo_next;
  logic [31:0]        quot_prod;
  logic [DUTY_W-1:0]  duty;
  logic [1:0]         status;
  logic [1:0]         route;
  logic               front_blocked;

  assign range16 = {cfg.max_range_cm, 4'b0000};
  assign vc16    = {cfg.very_close_cm, 4'b0000};
  assign warn16  = {cfg.warning_cm, 4'b0000};

  // step, bounce at the limits (upper first), then clamp to the servo span
  always_comb begin
    if (sweep_up) begin
      a_step = $signed({2'b00, sweep_angle}) + $signed({3'b000, cfg.sweep_step});
    end else begin
      a_step = $signed({2'b00, sweep_angle}) - $signed({3'b000, cfg.sweep_step});
    end
    a_bounce      = a_step;
    sweep_up_next = sweep_up;
    if (a_step >= $signed({2'b00, cfg.max_angle})) begin
      a_bounce      = $signed({2'b00, cfg.max_angle});
      sweep_up_next = 1'b0;
    end else if (a_step <= $signed({2'b00, cfg.min_angle})) begin
      a_bounce      = $signed({2'b00, cfg.min_angle});
      sweep_up_next = 1'b1;
    end
    if (a_bounce < 10'sd0) begin
      angle_next = '0;
    end else if (a_bounce > $signed({2'b00, ANGLE_FULL})) begin
      angle_next = ANGLE_FULL;
    end else begin
      angle_next = a_bounce[ANGLE_W-1:0];
    end
  end

  assign raw_prod = 24'(echo) * ECHO_SCALE;

  always_comb begin
    if (echo == '0 || raw < MIN_DIST || raw > range16) begin
      echo_target = range16;
    end else begin
      echo_target = raw;
    end
    smoothed_echo_next = ema(echo_target, smoothed_echo, ECHO_NEW_Q8, ECHO_OLD_Q8);
  end

  assign quot_prod = 32'(frac_prod) * DUTY_RECIP;

  always_comb begin
    duty = DUTY_BASE + 13'(sweep_angle) * DUTY_WHOLE + 13'(frac_quot);
    if (center_memory < vc16 || last_distance < vc16) begin
      status = STATUS_VERYCLOSE;
    end else if (center_memory < warn16 || last_distance < warn16) begin
      status = STATUS_OBSTACLE;
    end else begin
      status = STATUS_CLEAR;
    end
    if ({1'b0, left_memory} > {1'b0, right_memory} + PATH_MARGIN) begin
      route = PATH_LEFT;
    end else if ({1'b0, right_memory} > {1'b0, left_memory} + PATH_MARGIN) begin
      route = PATH_RIGHT;
    end else begin
      route = PATH_CENTER;
    end
    front_blocked = (center_memory < vc16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_angle   <= ANGLE_RESET;
      sweep_up      <= 1'b1;
      smoothed_echo <= DIST_RESET;
      last_distance <= DIST_RESET;
      left_memory   <= DIST_RESET;
      center_memory <= DIST_RESET;
      right_memory  <= DIST_RESET;
    end else begin
      if (cmd.angle) begin
        sweep_angle <= angle_next;
        sweep_up    <= sweep_up_next;
      end
      if (cmd.smooth) begin
        smoothed_echo <= smoothed_echo_next;
        last_distance <= (echo == '0) ? range16 : smoothed_echo_next;
      end
      if (cmd.sector) begin
        case (sector)
          SEC_LEFT:  left_memory <= ema(last_distance, left_memory, SECT_NEW_Q8, SECT_OLD_Q8);
          SEC_RIGHT: right_memory <= ema(last_distance, right_memory, SECT_NEW_Q8,
                                         SECT_OLD_Q8);
          default:   center_memory <= ema(last_distance, center_memory, SECT_NEW_Q8,
                                          SECT_OLD_Q8);
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      echo <= echo_in;
    end
    if (cmd.angle) begin
      raw <= raw_prod[23:10];
      if (angle_next >= ANGLE_LEFT) begin
        sector <= SEC_LEFT;
      end else if (angle_next <= ANGLE_RIGHT) begin
        sector <= SEC_RIGHT;
      end else begin
        sector <= SEC_CENTER;
      end
    end
    if (cmd.smooth) begin
      frac_prod <= 15'(sweep_angle) * DUTY_FRAC;
    end
    if (cmd.sector) begin
      frac_quot <= quot_prod[30:24];
    end
    if (cmd.finish) begin
      out_data <= {6'b000000, front_blocked, route, status, right_memory,
                   center_memory, left_memory, last_distance, duty, sweep_angle};
    end
  end

endmodule
